// File: src/ordered_distinct_value_list_assert.svh
// Assertion macros for the ordered distinct value list.
// Used by src/ordered_distinct_value_list.sv; depends on nothing else.
`ifndef ORDERED_DISTINCT_VALUE_LIST_ASSERT_SVH
`define ORDERED_DISTINCT_VALUE_LIST_ASSERT_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ODVL_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ordered_distinct_value_list: invariant violated");

// Checks that a condition is followed by a consequence in the next cycle.
`define ODVL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_distinct_value_list: sequencing violated");

`endif

// File: src/odvl_pkg.sv
// Package for the ordered distinct value list: item types, codes and the cell control struct.
// Used by src/odvl_cell.sv and src/ordered_distinct_value_list.sv; depends on nothing.
package odvl_pkg;

    // Field widths of the items.
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 4;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int FPOS_W   = 4;
    localparam int CNT_W    = 5;

    // Default number of list entries.
    localparam int DEF_CAPACITY = 16;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_ADD        = 4'd0;
    localparam logic [FUNC_W-1:0] FN_ADD_NEW    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd2;
    localparam logic [FUNC_W-1:0] FN_MOVE       = 4'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 4'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE_OLD = 4'd5;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd6;
    localparam logic [FUNC_W-1:0] FN_FIND       = 4'd7;
    localparam logic [FUNC_W-1:0] FN_READ       = 4'd8;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // One operation item.
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     found;
        logic [FPOS_W-1:0]        found_position;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         count;
    } t_out_item;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic                     cmp;   // compare entries with value and keep the hit flag
        logic                     wr;    // apply the shift window
        logic                     left;  // window shifts towards higher positions
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// File: src/odvl_cell.sv
// One list entry: holds a value, compares it with the broadcast value and shifts with its neighbours.
// Depends on odvl_pkg.
module odvl_cell #(
    parameter int CAPACITY = odvl_pkg::DEF_CAPACITY,
    parameter int INDEX    = 0
) (
    input  logic                                    i_clk,
    input  odvl_pkg::t_cell_ctl                     i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]             i_lo,
    input  logic [$clog2(CAPACITY)-1:0]             i_hi,
    input  logic [$clog2(CAPACITY+1)-1:0]           i_count,
    input  logic [odvl_pkg::POS_W-1:0]              i_rd_pos,
    input  logic signed [odvl_pkg::DATA_W-1:0]      i_left_entry,
    input  logic signed [odvl_pkg::DATA_W-1:0]      i_right_entry,
    output logic signed [odvl_pkg::DATA_W-1:0]      o_entry,
    output logic                                    o_hit,
    output logic [$clog2(CAPACITY)-1:0]             o_hit_idx,
    output logic signed [odvl_pkg::DATA_W-1:0]      o_rd
);
    import odvl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (AW > POS_W) ? AW : POS_W;

    localparam logic [AW-1:0] IDX   = AW'(INDEX);
    localparam logic [CW-1:0] IDX_C = CW'(INDEX);
    localparam logic [XW-1:0] IDX_X = XW'(INDEX);

    logic signed [DATA_W-1:0] r_entry;
    logic                     r_hit;
    logic signed [DATA_W-1:0] n_entry;

    // Choose the new entry from the shift window: the window's end cell takes the value.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.left) begin
            if (IDX == i_lo) begin
                n_entry = i_ctl.value;
            end else if (IDX > i_lo && IDX <= i_hi) begin
                n_entry = i_left_entry;
            end
        end else begin
            if (IDX == i_hi) begin
                n_entry = i_ctl.value;
            end else if (IDX >= i_lo && IDX < i_hi) begin
                n_entry = i_right_entry;
            end
        end
    end

    // Entry storage and the hit flag; only entries below the count can hit.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_entry <= n_entry;
        end
        if (i_ctl.cmp) begin
            r_hit <= (IDX_C < i_count) && (r_entry == i_ctl.value);
        end
    end

    assign o_entry   = r_entry;
    assign o_hit     = r_hit;
    assign o_hit_idx = r_hit ? IDX : '0;
    assign o_rd      = (XW'(i_rd_pos) == IDX_X) ? r_entry : '0;

endmodule

// File: src/ordered_distinct_value_list.sv
// Top level of the ordered distinct value list: sequencer, result register and the row of cells.
// Depends on odvl_pkg, odvl_cell and ordered_distinct_value_list_assert.svh.
//
//  Channel  | Ports                | Handshake
//  ---------+----------------------+--------------------------------------------
//  op in    | i_item               | taken at a clock edge with start high, busy low
//  result   | o_result             | shown one cycle, marked by o_result_valid
//
// For each item the cells compare on the accepting edge, the hit and read values are
// gathered into registers in the gather state, and the shift and result are applied in
// the apply state. The result strobe rises the cycle after that, while busy is
// already low, so a new item may be taken in the cycle the result is shown.
// Reset is synchronous and clears the count and the sequencer; entries are not cleared.
// The receiver cannot stall; results are never held back.
module ordered_distinct_value_list #(
    parameter int CAPACITY = odvl_pkg::DEF_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  odvl_pkg::t_in_item   i_item,
    output logic                 o_result_valid,
    output odvl_pkg::t_out_item  o_result
);
    import odvl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_APPLY
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    logic [FUNC_W-1:0]        r_func;
    logic signed [DATA_W-1:0] r_value;
    logic [POS_W-1:0]         r_pos;
    logic                     r_found;
    logic [AW-1:0]            r_at;
    logic signed [DATA_W-1:0] r_rd;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     accept;
    t_cell_ctl                w_ctl;
    logic [AW-1:0]            w_lo;
    logic [AW-1:0]            w_hi;

    logic signed [DATA_W-1:0] w_entry  [CAPACITY];
    logic                     w_hit    [CAPACITY];
    logic [AW-1:0]            w_hitidx [CAPACITY];
    logic signed [DATA_W-1:0] w_rdv    [CAPACITY];
    logic [CAPACITY-1:0]      w_hit_vec;

    logic                     g_found;
    logic [AW-1:0]            g_at;
    logic signed [DATA_W-1:0] g_rd;

    logic [STATUS_W-1:0]      n_status;
    logic [CW-1:0]            n_count;
    logic                     n_wr;
    logic                     n_left;
    logic [AW-1:0]            n_lo;
    logic [AW-1:0]            n_hi;
    logic signed [DATA_W-1:0] n_rd;
    t_out_item                n_out;

    logic [XW-1:0]            pos_x;
    logic [XW-1:0]            cnt_x;
    logic [XW-1:0]            at_x;
    logic                     full;
    logic [31:0]              at_w;
    logic [31:0]              cnt_w;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Broadcast control to the cells.
    assign w_ctl.cmp   = accept;
    assign w_ctl.wr    = (r_state == S_APPLY) && n_wr;
    assign w_ctl.left  = n_left;
    assign w_ctl.value = accept ? i_item.value : r_value;
    assign w_lo        = n_lo;
    assign w_hi        = n_hi;

    // Row of cells, each linked to its two neighbours.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_entry;
        logic signed [DATA_W-1:0] right_entry;

        if (g == 0) begin : g_first
            assign left_entry = '0;
        end else begin : g_inner_l
            assign left_entry = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner_r
            assign right_entry = w_entry[g+1];
        end

        odvl_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_lo          (w_lo),
            .i_hi          (w_hi),
            .i_count       (r_count),
            .i_rd_pos      (r_pos),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_entry       (w_entry[g]),
            .o_hit         (w_hit[g]),
            .o_hit_idx     (w_hitidx[g]),
            .o_rd          (w_rdv[g])
        );

        assign w_hit_vec[g] = w_hit[g];
    end

    // Gather the hit flag, its position and the read entry; values are distinct, so at most
    // one cell hits and a plain OR gives its position.
    always_comb begin
        g_found = 1'b0;
        g_at    = '0;
        g_rd    = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            g_found = g_found | w_hit[k];
            g_at    = g_at | w_hitidx[k];
            g_rd    = g_rd | w_rdv[k];
        end
    end

    // Decide the status, the new count and the shift window of the latched operation.
    assign pos_x = XW'(r_pos);
    assign cnt_x = XW'(r_count);
    assign at_x  = XW'(r_at);
    assign full  = (r_count >= CAP_C);

    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        n_wr     = 1'b0;
        n_left   = 1'b1;
        n_lo     = '0;
        n_hi     = '0;
        n_rd     = '0;
        case (r_func)
            FN_ADD, FN_ADD_NEW: begin
                if (r_found) begin
                    n_status = (r_func == FN_ADD) ? ST_PRESENT : ST_OK;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_wr    = 1'b1;
                    n_lo    = AW'(r_count);
                    n_hi    = AW'(r_count);
                    n_count = r_count + CW'(1);
                end
            end
            FN_INSERT: begin
                if (r_found) begin
                    n_status = ST_PRESENT;
                end else if (pos_x > cnt_x) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_wr    = 1'b1;
                    n_lo    = AW'(r_pos);
                    n_hi    = AW'(r_count);
                    n_count = r_count + CW'(1);
                end
            end
            FN_MOVE: begin
                if (!r_found) begin
                    n_status = ST_ABSENT;
                end else if (pos_x >= cnt_x) begin
                    n_status = ST_RANGE;
                end else if (pos_x < at_x) begin
                    n_wr = 1'b1;
                    n_lo = AW'(r_pos);
                    n_hi = r_at;
                end else begin
                    n_wr   = 1'b1;
                    n_left = 1'b0;
                    n_lo   = r_at;
                    n_hi   = AW'(r_pos);
                end
            end
            FN_REMOVE, FN_REMOVE_OLD: begin
                if (!r_found) begin
                    n_status = (r_func == FN_REMOVE) ? ST_ABSENT : ST_OK;
                end else begin
                    // The value lands past the new end, where it is never seen.
                    n_wr    = 1'b1;
                    n_left  = 1'b0;
                    n_lo    = r_at;
                    n_hi    = AW'(r_count - CW'(1));
                    n_count = r_count - CW'(1);
                end
            end
            FN_CLEAR: begin
                n_count = '0;
            end
            FN_READ: begin
                if (pos_x >= cnt_x) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd = r_rd;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Assemble the result item with positions and count cut to the field widths.
    assign at_w  = 32'(r_at);
    assign cnt_w = 32'(n_count);

    always_comb begin
        n_out                = '0;
        n_out.status         = n_status;
        n_out.found          = r_found;
        n_out.found_position = r_found ? at_w[FPOS_W-1:0] : '0;
        n_out.read_value     = n_rd;
        n_out.count          = cnt_w[CNT_W-1:0];
    end

    // Sequencer, list count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_item.func;
                        r_value <= i_item.value;
                        r_pos   <= i_item.position;
                        r_state <= S_GATHER;
                    end
                end
                S_GATHER: begin
                    r_found <= g_found;
                    r_at    <= g_at;
                    r_rd    <= g_rd;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_count     <= n_count;
                    r_out       <= n_out;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`include "ordered_distinct_value_list_assert.svh"

    // Stored values are distinct, so at most one cell may report a hit.
    `ODVL_ASSERT_ALWAYS(a_single_hit, i_clk, i_rst_n, (r_state != S_GATHER) || $onehot0(w_hit_vec))
    // The count never passes the capacity.
    `ODVL_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CAP_C)
    // The apply cycle is always followed by exactly one result strobe.
    `ODVL_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, r_state == S_APPLY, o_result_valid)
    // A strobe lasts a single cycle.
    `ODVL_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    // An accepted item makes the block busy in the next cycle.
    `ODVL_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, accept, busy)

endmodule
